// ----- src/rbps_pkg.sv -----
package rbps_pkg;

    // fixed coordinate width, Q16.16 by default
    localparam int COORD_W   = 32;
    localparam int NUM_AXES  = 3;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [COORD_W-1:0] t_coord;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INV_DIR_X = 3'd0,
        CFG_INV_DIR_Y = 3'd1,
        CFG_INV_DIR_Z = 3'd2,
        CFG_ORIGIN_X  = 3'd3,
        CFG_ORIGIN_Y  = 3'd4,
        CFG_ORIGIN_Z  = 3'd5,
        CFG_T_MIN     = 3'd6,
        CFG_T_MAX     = 3'd7
    } t_cfg_idx;

    // largest and smallest representable distance
    localparam t_coord COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // one box pair transaction
    typedef struct packed {
        t_coord box_a_min_x;
        t_coord box_a_min_y;
        t_coord box_a_min_z;
        t_coord box_a_max_x;
        t_coord box_a_max_y;
        t_coord box_a_max_z;
        t_coord box_b_min_x;
        t_coord box_b_min_y;
        t_coord box_b_min_z;
        t_coord box_b_max_x;
        t_coord box_b_max_y;
        t_coord box_b_max_z;
    } t_box_pair;

    // one result transaction
    typedef struct packed {
        logic   hit_a;
        logic   hit_b;
        t_coord near_a;
        t_coord near_b;
    } t_box_result;

endpackage

// ----- src/rbps_slab_mul.sv -----
module rbps_slab_mul #(
    parameter int FRAC_BITS = 16
) (
    input  rbps_pkg::t_coord i_bound,
    input  rbps_pkg::t_coord i_origin,
    input  rbps_pkg::t_coord i_inv,
    output rbps_pkg::t_coord o_dist
);
    import rbps_pkg::*;

    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = DIFF_W + COORD_W;

    logic signed [DIFF_W-1:0]  diff;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  shifted;
    logic [PROD_W-COORD_W:0]   top_bits;
    logic                      in_range;

    // exact difference, one bit wider than a coordinate
    assign diff = {i_bound[COORD_W-1], i_bound} - {i_origin[COORD_W-1], i_origin};

    // full signed product, floor shift back to the coordinate scale
    assign prod    = diff * i_inv;
    assign shifted = prod >>> FRAC_BITS;

    // saturate to the coordinate range
    assign top_bits = shifted[PROD_W-1:COORD_W-1];
    assign in_range = (&top_bits) | ~(|top_bits);

    always_comb begin
        if (in_range) begin
            o_dist = shifted[COORD_W-1:0];
        end else if (shifted[PROD_W-1]) begin
            o_dist = COORD_MIN;
        end else begin
            o_dist = COORD_MAX;
        end
    end

endmodule

// ----- src/rbps_box_reduce.sv -----
module rbps_box_reduce (
    input  rbps_pkg::t_coord i_t0 [rbps_pkg::NUM_AXES],
    input  rbps_pkg::t_coord i_t1 [rbps_pkg::NUM_AXES],
    input  rbps_pkg::t_coord i_t_min,
    input  rbps_pkg::t_coord i_t_max,
    output logic             o_hit,
    output rbps_pkg::t_coord o_near
);
    import rbps_pkg::*;

    t_coord ax_near [NUM_AXES];
    t_coord ax_far  [NUM_AXES];
    t_coord t_near;
    t_coord t_far;
    t_coord near_clamped;
    t_coord far_clamped;

    // per-axis slab ends, ordered
    always_comb begin
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            if (i_t0[ax] < i_t1[ax]) begin
                ax_near[ax] = i_t0[ax];
                ax_far[ax]  = i_t1[ax];
            end else begin
                ax_near[ax] = i_t1[ax];
                ax_far[ax]  = i_t0[ax];
            end
        end
    end

    // latest entry and earliest exit over the axes
    always_comb begin
        t_near = ax_near[0];
        t_far  = ax_far[0];
        for (int ax = 1; ax < NUM_AXES; ax++) begin
            if (ax_near[ax] > t_near) begin
                t_near = ax_near[ax];
            end
            if (ax_far[ax] < t_far) begin
                t_far = ax_far[ax];
            end
        end
    end

    // clamp to the ray interval
    assign near_clamped = (i_t_min > t_near) ? i_t_min : t_near;
    assign far_clamped  = (i_t_max < t_far)  ? i_t_max : t_far;

    assign o_near = near_clamped;
    assign o_hit  = (near_clamped <= far_clamped);

endmodule

// ----- src/ray_box_pair_slab_test_core.sv -----
// ray versus box pair slab test, fixed point
// result strobe o_done rises once the start transaction has passed the input, distance and result registers
// throughput: one box pair per cycle; o_busy is never raised
// the three register stages are input, per-axis distances and result
// synchronous active-low reset clears the pipeline valids and the ray registers
// results are strobed for one cycle only, the receiver cannot stall
module ray_box_pair_slab_test_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rbps_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  rbps_pkg::t_coord                    i_cfg_data,
    input  logic                                i_start,
    input  rbps_pkg::t_box_pair                 i_box,
    output logic                                o_busy,
    output logic                                o_done,
    output rbps_pkg::t_box_result               o_result
);
    import rbps_pkg::*;

    // ray registers
    t_coord r_inv [NUM_AXES];
    t_coord r_org [NUM_AXES];
    t_coord r_t_min;
    t_coord r_t_max;

    // pipeline
    logic        r_v1;
    logic        r_v2;
    logic        r_v3;
    t_box_pair   r_in;
    t_coord      r_ta_lo [NUM_AXES];
    t_coord      r_ta_hi [NUM_AXES];
    t_coord      r_tb_lo [NUM_AXES];
    t_coord      r_tb_hi [NUM_AXES];
    t_box_result r_res;

    t_coord a_lo [NUM_AXES];
    t_coord a_hi [NUM_AXES];
    t_coord b_lo [NUM_AXES];
    t_coord b_hi [NUM_AXES];
    t_coord n_ta_lo [NUM_AXES];
    t_coord n_ta_hi [NUM_AXES];
    t_coord n_tb_lo [NUM_AXES];
    t_coord n_tb_hi [NUM_AXES];
    t_box_result n_res;
    logic        accept;

    assign o_busy = 1'b0;
    assign accept = i_start & ~o_busy;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int ax = 0; ax < NUM_AXES; ax++) begin
                r_inv[ax] <= '0;
                r_org[ax] <= '0;
            end
            r_t_min <= '0;
            r_t_max <= COORD_MAX;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_INV_DIR_X: r_inv[0] <= i_cfg_data;
                CFG_INV_DIR_Y: r_inv[1] <= i_cfg_data;
                CFG_INV_DIR_Z: r_inv[2] <= i_cfg_data;
                CFG_ORIGIN_X:  r_org[0] <= i_cfg_data;
                CFG_ORIGIN_Y:  r_org[1] <= i_cfg_data;
                CFG_ORIGIN_Z:  r_org[2] <= i_cfg_data;
                CFG_T_MIN:     r_t_min  <= i_cfg_data;
                CFG_T_MAX:     r_t_max  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_box;
        end
    end

    // bounds by axis
    assign a_lo[0] = r_in.box_a_min_x;
    assign a_lo[1] = r_in.box_a_min_y;
    assign a_lo[2] = r_in.box_a_min_z;
    assign a_hi[0] = r_in.box_a_max_x;
    assign a_hi[1] = r_in.box_a_max_y;
    assign a_hi[2] = r_in.box_a_max_z;
    assign b_lo[0] = r_in.box_b_min_x;
    assign b_lo[1] = r_in.box_b_min_y;
    assign b_lo[2] = r_in.box_b_min_z;
    assign b_hi[0] = r_in.box_b_max_x;
    assign b_hi[1] = r_in.box_b_max_y;
    assign b_hi[2] = r_in.box_b_max_z;

    // twelve slab distance lanes
    for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_axis
        rbps_slab_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_a_lo (
            .i_bound(a_lo[ax]), .i_origin(r_org[ax]), .i_inv(r_inv[ax]),
            .o_dist(n_ta_lo[ax])
        );
        rbps_slab_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_a_hi (
            .i_bound(a_hi[ax]), .i_origin(r_org[ax]), .i_inv(r_inv[ax]),
            .o_dist(n_ta_hi[ax])
        );
        rbps_slab_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_b_lo (
            .i_bound(b_lo[ax]), .i_origin(r_org[ax]), .i_inv(r_inv[ax]),
            .o_dist(n_tb_lo[ax])
        );
        rbps_slab_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_b_hi (
            .i_bound(b_hi[ax]), .i_origin(r_org[ax]), .i_inv(r_inv[ax]),
            .o_dist(n_tb_hi[ax])
        );
    end

    // distance register
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_ta_lo <= n_ta_lo;
            r_ta_hi <= n_ta_hi;
            r_tb_lo <= n_tb_lo;
            r_tb_hi <= n_tb_hi;
        end
    end

    // per-box reduction and clamp
    rbps_box_reduce u_reduce_a (
        .i_t0(r_ta_lo), .i_t1(r_ta_hi),
        .i_t_min(r_t_min), .i_t_max(r_t_max),
        .o_hit(n_res.hit_a), .o_near(n_res.near_a)
    );

    rbps_box_reduce u_reduce_b (
        .i_t0(r_tb_lo), .i_t1(r_tb_hi),
        .i_t_min(r_t_min), .i_t_max(r_t_max),
        .o_hit(n_res.hit_b), .o_near(n_res.near_b)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_res <= n_res;
        end
    end

    assign o_done   = r_v3;
    assign o_result = r_res;

endmodule

// ----- src/rbps_checker.sv -----
module rbps_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_done
);

    // the block never holds off a transaction
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("busy raised");

    // every accepted transaction yields a result on o_done
    a_start_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##3 o_done)
        else $error("result missing after start");

    // no result without a matching start
    a_done_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, 3))
        else $error("result without start");

    // pipeline empty straight after reset
    a_reset_flush: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_done ##1 !o_done ##1 !o_done)
        else $error("result after reset");

endmodule

bind ray_box_pair_slab_test_core rbps_checker u_rbps_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_start(i_start),
    .o_busy(o_busy),
    .o_done(o_done)
);
